[rtl/core/jsu_pkg.sv]
package jsu_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_STR  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        K_BYTE    = 3'd0,
        K_DONE    = 3'd1,
        K_NOQUOTE = 3'd2,
        K_BADESC  = 3'd3,
        K_BADHEX  = 3'd4,
        K_UNTERM  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        kind_t      kind;
        logic [9:0] kept_length;
        logic       last;
    } result_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] REPL_B0   = 8'hEF;
    localparam logic [7:0] REPL_B1   = 8'hBF;
    localparam logic [7:0] REPL_B2   = 8'hBD;

    localparam logic [9:0] KEEP_LIMIT_RST = 10'd1023;
    localparam logic [2:0] ADDR_KEEP_LIMIT = 3'd0;

    // bit 4 set when the byte is a hex digit, value in bits 3:0
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        case (c) inside
            [CH_D0:CH_D9]:     r = {1'b1, 4'(c - CH_D0)};
            [CH_LO_A:CH_LO_F]: r = {1'b1, 4'(c - CH_LO_A + 8'd10)};
            [CH_UP_A:CH_UP_F]: r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
            default:           r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/json_string_unescape_utf8.sv]
// JSON string unescaper: takes one byte of JSON text per word on the slave side and
// gives decoded UTF-8 string bytes, a done word carrying the kept length, or an error
// word on the master side. Each text byte is decoded in the cycle it is accepted and its
// zero to three result words go into a four-word result queue; s_tready is high while at
// most one word is queued, so a text byte is taken every clock as long as the sink keeps
// up. A \uXXXX escape that ends in a two- or three-byte sequence queues up to that many
// words, and the slave side pauses while they drain. keep_limit (address 0, reset 1023)
// caps the bytes passed out per string; the rest are dropped silently.
module json_string_unescape_utf8 (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tuser,   // [0] op: 0 data byte, 1 end of input
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [17:8] kept_length, [23:18] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jsu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_seen_reg, hex_seen_next;
    logic [11:0] acc_reg, acc_next;
    logic [9:0]  kept_reg, kept_next;
    logic [9:0]  keep_limit_reg;

    result_t     queue_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;

    logic        in_accept, out_accept;
    logic [4:0]  hd;
    logic [15:0] code;
    logic [7:0]  cand [3];
    logic [1:0]  nb, nput, n_res;
    logic        spec_valid;
    kind_t       spec_kind;
    logic [9:0]  spec_len;
    logic [9:0]  avail;
    result_t     res [3];

    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;
    assign s_tready   = (count_reg <= 3'd1);

    assign hd   = hex_digit(s_tdata);
    assign code = {acc_reg, hd[3:0]};

    always_comb
    begin
        phase_next    = phase_reg;
        hex_seen_next = hex_seen_reg;
        acc_next      = acc_reg;
        kept_next     = kept_reg;
        nb            = 2'd0;
        cand[0]       = 8'd0;
        cand[1]       = 8'd0;
        cand[2]       = 8'd0;
        spec_valid    = 1'b0;
        spec_kind     = K_BYTE;
        spec_len      = 10'd0;

        if (in_accept)
        begin
            if (s_tuser)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    spec_valid = 1'b1;
                    spec_kind  = K_UNTERM;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (s_tdata == CH_QUOTE)
                        begin
                            phase_next = PH_STR;
                            kept_next  = 10'd0;
                        end
                        else if (s_tdata != CH_SPACE && s_tdata != CH_TAB &&
                                 s_tdata != CH_CR && s_tdata != CH_LF)
                        begin
                            spec_valid = 1'b1;
                            spec_kind  = K_NOQUOTE;
                        end
                    end
                    PH_STR:
                    begin
                        if (s_tdata == CH_QUOTE)
                        begin
                            spec_valid = 1'b1;
                            spec_kind  = K_DONE;
                            spec_len   = kept_reg;
                        end
                        else if (s_tdata == CH_BSL)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            nb      = 2'd1;
                            cand[0] = s_tdata;
                        end
                    end
                    PH_ESC:
                    begin
                        phase_next = PH_STR;
                        nb         = 2'd1;
                        case (s_tdata)
                            CH_QUOTE: cand[0] = CH_QUOTE;
                            CH_BSL:   cand[0] = CH_BSL;
                            CH_SLASH: cand[0] = CH_SLASH;
                            CH_LO_B:  cand[0] = CH_BS;
                            CH_LO_F:  cand[0] = CH_FF;
                            CH_LO_N:  cand[0] = CH_LF;
                            CH_LO_R:  cand[0] = CH_CR;
                            CH_LO_T:  cand[0] = CH_TAB;
                            CH_LO_U:
                            begin
                                nb            = 2'd0;
                                phase_next    = PH_HEX;
                                hex_seen_next = 2'd0;
                                acc_next      = 12'd0;
                            end
                            default:
                            begin
                                nb         = 2'd0;
                                spec_valid = 1'b1;
                                spec_kind  = K_BADESC;
                            end
                        endcase
                    end
                    PH_HEX:
                    begin
                        if (!hd[4])
                        begin
                            spec_valid = 1'b1;
                            spec_kind  = K_BADHEX;
                        end
                        else if (hex_seen_reg != 2'd3)
                        begin
                            acc_next      = {acc_reg[7:0], hd[3:0]};
                            hex_seen_next = hex_seen_reg + 2'd1;
                        end
                        else
                        begin
                            hex_seen_next = 2'd0;
                            acc_next      = 12'd0;
                            phase_next    = PH_STR;
                            if (code[15:7] == 9'd0)
                            begin
                                nb      = 2'd1;
                                cand[0] = code[7:0];
                            end
                            else if (code[15:11] == 5'd0)
                            begin
                                nb      = 2'd2;
                                cand[0] = UTF_LEAD2 | {3'd0, code[10:6]};
                                cand[1] = UTF_CONT | {2'd0, code[5:0]};
                            end
                            else if (code[15:11] == 5'b11011)
                            begin
                                // surrogate half: substitute the replacement character
                                nb      = 2'd3;
                                cand[0] = REPL_B0;
                                cand[1] = REPL_B1;
                                cand[2] = REPL_B2;
                            end
                            else
                            begin
                                nb      = 2'd3;
                                cand[0] = UTF_LEAD3 | {4'd0, code[15:12]};
                                cand[1] = UTF_CONT | {2'd0, code[11:6]};
                                cand[2] = UTF_CONT | {2'd0, code[5:0]};
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end

            if (spec_valid)
            begin
                phase_next    = PH_IDLE;
                hex_seen_next = 2'd0;
                acc_next      = 12'd0;
                kept_next     = 10'd0;
            end
        end
    end

    // trim decoded bytes to what the keep limit still allows
    always_comb
    begin
        avail = (kept_reg < keep_limit_reg) ? (keep_limit_reg - kept_reg) : 10'd0;
        nput  = (avail >= {8'd0, nb}) ? nb : avail[1:0];
    end

    always_comb
    begin
        n_res = spec_valid ? 2'd1 : nput;
        for (int k = 0; k < 3; k++)
        begin
            if (spec_valid)
            begin
                res[k] = '{data_byte: 8'd0, kind: spec_kind, kept_length: spec_len,
                           last: 1'b1};
            end
            else
            begin
                res[k] = '{data_byte: cand[k], kind: K_BYTE, kept_length: 10'd0,
                           last: (2'(k) == nput - 2'd1)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            hex_seen_reg <= 2'd0;
            acc_reg      <= 12'd0;
            kept_reg     <= 10'd0;
            wr_ptr_reg   <= 2'd0;
            rd_ptr_reg   <= 2'd0;
            count_reg    <= 3'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hex_seen_reg <= hex_seen_next;
            acc_reg      <= acc_next;
            kept_reg     <= (in_accept && !spec_valid && nb != 2'd0) ?
                            kept_reg + {8'd0, nput} : kept_next;
            if (in_accept)
                wr_ptr_reg <= wr_ptr_reg + n_res;
            if (out_accept)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (in_accept ? {1'b0, n_res} : 3'd0)
                         - {2'd0, out_accept};
        end
    end

    // result queue payload, no reset
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (in_accept && 2'(k) < n_res)
                queue_reg[wr_ptr_reg + 2'(k)] <= res[k];
        end
    end

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {6'd0, queue_reg[rd_ptr_reg].kept_length,
                       queue_reg[rd_ptr_reg].data_byte};
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_KEEP_LIMIT) ? {22'd0, keep_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keep_limit_reg <= KEEP_LIMIT_RST;
        else if (psel && penable && pwrite && pready && paddr == ADDR_KEEP_LIMIT)
            keep_limit_reg <= pwdata[9:0];
    end

endmodule

[tb/json_unescape_check.sv]
module json_unescape_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tuser,   // [0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] data_byte, [17:8] kept_length, [23:18] zero
    input  logic [2:0]  m_tuser,   // [2:0] kind
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // shadow copy of the decoder state
    phase_t      str_phase;
    logic [1:0]  digits_seen;
    logic [11:0] code_acc;
    logic [9:0]  kept_bytes;
    logic [9:0]  keep_limit;

    result_t expected_words[$];
    result_t step_words[3];
    int      step_count;
    result_t got;
    result_t want;

    task automatic add_word(input logic [7:0] b, input kind_t k, input logic [9:0] len);
        result_t w;
        w.data_byte   = b;
        w.kind        = k;
        w.kept_length = len;
        w.last        = 1'b0;
        step_words[step_count] = w;
        step_count++;
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (kept_bytes < keep_limit)
        begin
            add_word(b, K_BYTE, 10'd0);
            kept_bytes++;
        end
    endtask

    task automatic go_idle();
        str_phase   = PH_IDLE;
        digits_seen = 2'd0;
        code_acc    = 12'd0;
        kept_bytes  = 10'd0;
    endtask

    task automatic encode_code(input logic [15:0] cp);
        if (cp < 16'h0080)
        begin
            keep_byte(cp[7:0]);
        end
        else if (cp < 16'h0800)
        begin
            keep_byte(UTF_LEAD2 | {3'd0, cp[10:6]});
            keep_byte(UTF_CONT | {2'd0, cp[5:0]});
        end
        else if (cp >= 16'hD800 && cp <= 16'hDFFF)
        begin
            // lone surrogate half becomes the replacement character
            keep_byte(REPL_B0);
            keep_byte(REPL_B1);
            keep_byte(REPL_B2);
        end
        else
        begin
            keep_byte(UTF_LEAD3 | {4'd0, cp[15:12]});
            keep_byte(UTF_CONT | {2'd0, cp[11:6]});
            keep_byte(UTF_CONT | {2'd0, cp[5:0]});
        end
    endtask

    task automatic decode_text_word(input logic op, input logic [7:0] c);
        logic [7:0] esc;
        logic       esc_ok;
        logic       is_hex;
        logic [7:0] t;
        int         i;
        step_count = 0;
        esc = 8'd0;
        t = 8'd0;
        if (op)
        begin
            if (str_phase != PH_IDLE)
            begin
                add_word(8'd0, K_UNTERM, 10'd0);
                go_idle();
            end
        end
        else
        begin
            case (str_phase)
                PH_IDLE:
                begin
                    if (c == CH_QUOTE)
                    begin
                        str_phase  = PH_STR;
                        kept_bytes = 10'd0;
                    end
                    else if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_LF)
                    begin
                        add_word(8'd0, K_NOQUOTE, 10'd0);
                        go_idle();
                    end
                end
                PH_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        add_word(8'd0, K_DONE, kept_bytes);
                        go_idle();
                    end
                    else if (c == CH_BSL)
                        str_phase = PH_ESC;
                    else
                        keep_byte(c);
                end
                PH_ESC:
                begin
                    str_phase = PH_STR;
                    esc_ok = 1'b1;
                    case (c)
                        CH_QUOTE: esc = CH_QUOTE;
                        CH_BSL:   esc = CH_BSL;
                        CH_SLASH: esc = CH_SLASH;
                        CH_LO_B:  esc = CH_BS;
                        CH_LO_F:  esc = CH_FF;
                        CH_LO_N:  esc = CH_LF;
                        CH_LO_R:  esc = CH_CR;
                        CH_LO_T:  esc = CH_TAB;
                        CH_LO_U:
                        begin
                            str_phase   = PH_HEX;
                            digits_seen = 2'd0;
                            code_acc    = 12'd0;
                            esc_ok      = 1'b0;
                        end
                        default:
                        begin
                            add_word(8'd0, K_BADESC, 10'd0);
                            go_idle();
                            esc_ok = 1'b0;
                        end
                    endcase
                    if (esc_ok)
                        keep_byte(esc);
                end
                default:
                begin
                    is_hex = 1'b1;
                    if (c >= CH_D0 && c <= CH_D9)
                        t = c - CH_D0;
                    else if (c >= CH_LO_A && c <= CH_LO_F)
                        t = c - CH_LO_A + 8'd10;
                    else if (c >= CH_UP_A && c <= CH_UP_F)
                        t = c - CH_UP_A + 8'd10;
                    else
                        is_hex = 1'b0;
                    if (!is_hex)
                    begin
                        add_word(8'd0, K_BADHEX, 10'd0);
                        go_idle();
                    end
                    else if (digits_seen < 2'd3)
                    begin
                        code_acc = {code_acc[7:0], t[3:0]};
                        digits_seen++;
                    end
                    else
                    begin
                        encode_code({code_acc, t[3:0]});
                        digits_seen = 2'd0;
                        code_acc    = 12'd0;
                        str_phase   = PH_STR;
                    end
                end
            endcase
        end
        if (step_count > 0)
            step_words[step_count - 1].last = 1'b1;
        for (i = 0; i < step_count; i++)
            expected_words.push_back(step_words[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit = KEEP_LIMIT_RST;
            go_idle();
            expected_words.delete();
            fail_count = 0;
            open_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_KEEP_LIMIT)
                keep_limit = pwdata[9:0];
            if (s_tvalid && s_tready)
                decode_text_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.data_byte   = m_tdata[7:0];
                got.kind        = kind_t'(m_tuser);
                got.kept_length = m_tdata[17:8];
                got.last        = m_tlast;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: data_byte %0h kind %0d %s %0d last %0b",
                           got.data_byte, got.kind, "kept_length", got.kept_length,
                           got.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                        fail_count++;
                    end
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.kept_length !== want.kept_length)
                    begin
                        $error("kept_length: expected %0d, got %0d",
                               want.kept_length, got.kept_length);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            open_count = expected_words.size();
        end
    end

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int CYCLE_LIMIT      = 60000;
    localparam int SINK_HOLD_CYCLES = 64;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int open_count;
    int items_sent;
    int cycle_count;
    bit jitter_on     = 1'b1;
    bit sink_hold_req = 1'b0;

    logic [7:0] escape_chars [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_LO_B,
                                     CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T};
    logic [7:0] ws_chars [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    json_string_unescape_utf8 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    json_unescape_check unescape_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // sink: random short stalls, plus one long hold on request
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (jitter_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return CH_D0 + {4'd0, n};
        return (upper ? CH_UP_A : CH_LO_A) + {4'd0, n} - 8'd10;
    endfunction

    task automatic send_text(input logic op, input logic [7:0] b);
        if (jitter_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // drop valid and let every queued word drain before touching registers
    task automatic settle_block();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (open_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_keep_limit(input logic [9:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_KEEP_LIMIT;
        pwdata  <= {22'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_string();
        int         pieces;
        int         k;
        int         ending;
        int         ndig;
        logic [15:0] cp;
        logic [7:0]  b;
        bit          good;
        if ($urandom_range(0, 3) == 0)
            send_text(1'b0, ws_chars[$urandom_range(0, 3)]);
        send_text(1'b0, CH_QUOTE);
        pieces = $urandom_range(0, 6);
        for (k = 0; k < pieces; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_BSL)
                        b = 8'($urandom_range(0, 255));
                    send_text(1'b0, b);
                end
                4, 5:
                begin
                    send_text(1'b0, CH_BSL);
                    send_text(1'b0, escape_chars[$urandom_range(0, 7)]);
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       cp = 16'($urandom_range(0, 'h7F));
                        1:       cp = 16'($urandom_range('h80, 'h7FF));
                        2:       cp = 16'($urandom_range('hD800, 'hDFFF));
                        default: cp = 16'($urandom_range('h800, 'hFFFF));
                    endcase
                    send_text(1'b0, CH_BSL);
                    send_text(1'b0, CH_LO_U);
                    for (ndig = 3; ndig >= 0; ndig--)
                        send_text(1'b0, hex_char(cp[ndig*4 +: 4], 1'($urandom_range(0, 1))));
                end
            endcase
        end
        ending = $urandom_range(0, 11);
        if (ending < 8)
            send_text(1'b0, CH_QUOTE);
        else if (ending == 8)
            send_text(1'b1, 8'($urandom_range(0, 255)));
        else if (ending == 9)
        begin
            send_text(1'b0, CH_BSL);
            do
            begin
                b = 8'($urandom_range(0, 255));
                case (b)
                    CH_QUOTE, CH_BSL, CH_SLASH, CH_LO_B, CH_LO_F,
                    CH_LO_N, CH_LO_R, CH_LO_T, CH_LO_U: good = 1'b0;
                    default:                            good = 1'b1;
                endcase
            end
            while (!good);
            send_text(1'b0, b);
        end
        else
        begin
            // broken escape: bad hex digit, or end of text after the backslash or mid-hex
            send_text(1'b0, CH_BSL);
            if (ending == 10 || $urandom_range(0, 1) == 1)
            begin
                send_text(1'b0, CH_LO_U);
                ndig = $urandom_range(0, 3);
                for (k = 0; k < ndig; k++)
                    send_text(1'b0, hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1))));
            end
            if (ending == 10)
            begin
                do b = 8'($urandom_range(0, 255));
                while ((b >= CH_D0 && b <= CH_D9) || (b >= CH_LO_A && b <= CH_LO_F) ||
                       (b >= CH_UP_A && b <= CH_UP_F));
                send_text(1'b0, b);
            end
            else
                send_text(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count);
        int         stop_at;
        logic [7:0] b;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_SPACE || b == CH_TAB ||
                           b == CH_CR || b == CH_LF)
                        b = 8'($urandom_range(0, 255));
                    send_text(1'b0, b);
                end
                1:       send_text(1'b1, 8'($urandom_range(0, 255)));
                default: send_random_string();
            endcase
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 3'd0;
        pwdata   <= 32'd0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle handling: white space, stray byte, end of text with nothing open
        send_text(1'b0, CH_SPACE);
        send_text(1'b0, CH_TAB);
        send_text(1'b0, 8'h78);
        send_text(1'b1, 8'hFF);
        // byte extremes, a simple escape, a surrogate and the top code point
        send_text(1'b0, CH_QUOTE);
        send_text(1'b0, 8'h00);
        send_text(1'b0, 8'hFF);
        send_text(1'b0, CH_BSL);
        send_text(1'b0, CH_LO_N);
        send_text(1'b0, CH_BSL);
        send_text(1'b0, CH_LO_U);
        send_text(1'b0, hex_char(4'hD, 1'b1));
        send_text(1'b0, hex_char(4'h8, 1'b0));
        send_text(1'b0, hex_char(4'h0, 1'b0));
        send_text(1'b0, hex_char(4'h0, 1'b0));
        send_text(1'b0, CH_BSL);
        send_text(1'b0, CH_LO_U);
        send_text(1'b0, hex_char(4'hF, 1'b0));
        send_text(1'b0, hex_char(4'hF, 1'b1));
        send_text(1'b0, hex_char(4'hF, 1'b0));
        send_text(1'b0, hex_char(4'hF, 1'b1));
        send_text(1'b0, CH_QUOTE);
        // bad escape, bad hex digit, unterminated string
        send_text(1'b0, CH_QUOTE);
        send_text(1'b0, CH_BSL);
        send_text(1'b0, 8'h71);
        send_text(1'b0, CH_QUOTE);
        send_text(1'b0, CH_BSL);
        send_text(1'b0, CH_LO_U);
        send_text(1'b0, 8'h67);
        send_text(1'b0, CH_QUOTE);
        send_text(1'b1, 8'h00);

        settle_block();
        write_keep_limit(10'd0);
        run_random(20);

        settle_block();
        write_keep_limit(10'd2);
        run_random(20);

        // long sink hold while text keeps coming: fills the result queue
        settle_block();
        write_keep_limit(10'd1023);
        sink_hold_req = 1'b1;
        run_random(25);

        settle_block();
        write_keep_limit(10'($urandom_range(1, 8)));
        jitter_on = 1'b0;
        run_random(20);

        settle_block();
        if (fail_count == 0 && open_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/jsu_pkg.sv
rtl/core/json_string_unescape_utf8.sv
tb/json_unescape_check.sv
tb/tb.sv
